>>> rtl/sfpx_pkg.sv
// Shared types and constants for the serial frame parser with XOR checksum.
package sfpx_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LIMIT_W       = 9;
  localparam int unsigned EVENT_W       = 3;
  localparam int unsigned FAULT_TOTAL_W = 16;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned CFG_DATA_W    = 9;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_FIRST   = 3'd0,
    REG_HEADER_SECOND  = 3'd1,
    REG_TAIL_FIRST     = 3'd2,
    REG_TAIL_SECOND    = 3'd3,
    REG_FUNCTION_LIMIT = 3'd4,
    REG_LENGTH_LIMIT   = 3'd5
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0]  HEADER_FIRST_RST   = 8'hFF;
  localparam logic [BYTE_W-1:0]  HEADER_SECOND_RST  = 8'hFC;
  localparam logic [BYTE_W-1:0]  TAIL_FIRST_RST     = 8'hA1;
  localparam logic [BYTE_W-1:0]  TAIL_SECOND_RST    = 8'hA2;
  localparam logic [LIMIT_W-1:0] FUNCTION_LIMIT_RST = 9'd241;
  localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST   = 9'd100;

  typedef enum logic [EVENT_W-1:0] {
    EV_ABSORB  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BADSUM  = 3'd3,
    EV_FRAMING = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADER1  = 3'd1,
    PH_HEADER2  = 3'd2,
    PH_FUNCTION = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CHECKSUM = 3'd5,
    PH_TAIL1    = 3'd6,
    PH_TAIL2    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  header_first;
    logic [BYTE_W-1:0]  header_second;
    logic [BYTE_W-1:0]  tail_first;
    logic [BYTE_W-1:0]  tail_second;
    logic [LIMIT_W-1:0] function_limit;
    logic [LIMIT_W-1:0] length_limit;
  } cfg_t;

  typedef struct packed {
    event_t                    event_res;
    logic [BYTE_W-1:0]         payload_byte;
    logic                      last_payload;
    logic [BYTE_W-1:0]         function_code;
    logic [BYTE_W-1:0]         payload_length;
    logic [FAULT_TOTAL_W-1:0]  fault_total;
  } result_t;

endpackage

>>> rtl/sfpx_in_if.sv
// Input channel carrying one received byte per transaction.
interface sfpx_in_if
  import sfpx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sfpx_out_if.sv
// Result channel carrying one parser event per transaction.
interface sfpx_out_if
  import sfpx_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [EVENT_W-1:0]       event_res;
  logic [BYTE_W-1:0]        payload_byte;
  logic                     last_payload;
  logic [BYTE_W-1:0]        function_code;
  logic [BYTE_W-1:0]        payload_length;
  logic [FAULT_TOTAL_W-1:0] fault_total;

  modport source (
    output valid, output event_res, output payload_byte, output last_payload,
    output function_code, output payload_length, output fault_total,
    input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input last_payload,
    input function_code, input payload_length, input fault_total,
    output ready
  );
endinterface

>>> rtl/sfpx_cfg_if.sv
// Configuration write channel: register index and write data.
interface sfpx_cfg_if
  import sfpx_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sfpx_fsm.sv
// Frame state machine: phase, checksum accumulation and fault counting.
module sfpx_fsm
  import sfpx_pkg::*;
#(
  parameter int unsigned FAULT_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output result_t           result
);

  phase_t                      phase_r, phase_nxt;
  logic [BYTE_W-1:0]           bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0]           running_xor_r, running_xor_nxt;
  logic [BYTE_W-1:0]           frame_function_r, frame_function_nxt;
  logic [BYTE_W-1:0]           frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0]           checksum_seen_r, checksum_seen_nxt;
  logic [FAULT_COUNT_BITS-1:0] fault_r, fault_nxt;
  logic                        byte_ok;
  logic                        last_byte;
  logic [BYTE_W-1:0]           bytes_dec;

  assign bytes_dec = bytes_left_r - 1'b1;
  assign last_byte = (bytes_dec == '0);

  // Whether the byte fits what the current phase expects.
  always_comb begin
    case (phase_r)
      PH_IDLE:     byte_ok = (rx_byte == cfg.header_first);
      PH_HEADER1:  byte_ok = (rx_byte == cfg.header_second);
      PH_HEADER2:  byte_ok = ({1'b0, rx_byte} < cfg.function_limit);
      PH_FUNCTION: byte_ok = (rx_byte != '0) && ({1'b0, rx_byte} < cfg.length_limit);
      PH_PAYLOAD:  byte_ok = (bytes_left_r != '0);
      PH_CHECKSUM: byte_ok = 1'b1;
      PH_TAIL1:    byte_ok = (rx_byte == cfg.tail_first);
      PH_TAIL2:    byte_ok = (rx_byte == cfg.tail_second);
      default:     byte_ok = 1'b0;
    endcase
  end

  // Next state and frame bookkeeping.
  always_comb begin
    phase_nxt          = phase_r;
    bytes_left_nxt     = bytes_left_r;
    running_xor_nxt    = running_xor_r;
    frame_function_nxt = frame_function_r;
    frame_length_nxt   = frame_length_r;
    checksum_seen_nxt  = checksum_seen_r;
    fault_nxt          = fault_r;
    if (!byte_ok) begin
      phase_nxt = PH_IDLE;
      if (fault_r != '1) begin
        fault_nxt = fault_r + 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          running_xor_nxt = rx_byte;
          phase_nxt       = PH_HEADER1;
        end
        PH_HEADER1: begin
          running_xor_nxt = running_xor_r ^ rx_byte;
          phase_nxt       = PH_HEADER2;
        end
        PH_HEADER2: begin
          running_xor_nxt    = running_xor_r ^ rx_byte;
          frame_function_nxt = rx_byte;
          phase_nxt          = PH_FUNCTION;
        end
        PH_FUNCTION: begin
          running_xor_nxt  = running_xor_r ^ rx_byte;
          frame_length_nxt = rx_byte;
          bytes_left_nxt   = rx_byte;
          phase_nxt        = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_xor_nxt = running_xor_r ^ rx_byte;
          bytes_left_nxt  = bytes_dec;
          if (last_byte) begin
            phase_nxt = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          checksum_seen_nxt = rx_byte;
          phase_nxt         = PH_TAIL1;
        end
        PH_TAIL1: phase_nxt = PH_TAIL2;
        PH_TAIL2: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Result for the byte being processed.
  always_comb begin
    result                = '0;
    result.event_res      = EV_ABSORB;
    if (!byte_ok) begin
      result.event_res = EV_FRAMING;
    end else begin
      case (phase_r)
        PH_PAYLOAD: begin
          result.event_res    = EV_PAYLOAD;
          result.payload_byte = rx_byte;
          result.last_payload = last_byte;
        end
        PH_TAIL2: begin
          result.event_res = (running_xor_r == checksum_seen_r) ? EV_GOOD : EV_BADSUM;
        end
        default: result.event_res = EV_ABSORB;
      endcase
    end
    if (result.event_res == EV_PAYLOAD || result.event_res == EV_GOOD ||
        result.event_res == EV_BADSUM) begin
      result.function_code  = frame_function_r;
      result.payload_length = frame_length_r;
    end
    if (FAULT_COUNT_BITS > FAULT_TOTAL_W) begin
      // A count beyond the shown width reads as the all-ones value.
      result.fault_total = ((fault_nxt >> FAULT_TOTAL_W) != '0) ? '1
                                                                  : FAULT_TOTAL_W'(fault_nxt);
    end else begin
      result.fault_total = FAULT_TOTAL_W'(fault_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      bytes_left_r     <= '0;
      running_xor_r    <= '0;
      frame_function_r <= '0;
      frame_length_r   <= '0;
      checksum_seen_r  <= '0;
      fault_r          <= '0;
    end else if (step_en) begin
      phase_r          <= phase_nxt;
      bytes_left_r     <= bytes_left_nxt;
      running_xor_r    <= running_xor_nxt;
      frame_function_r <= frame_function_nxt;
      frame_length_r   <= frame_length_nxt;
      checksum_seen_r  <= checksum_seen_nxt;
      fault_r          <= fault_nxt;
    end
  end

  // The payload phase is only entered with a non-zero byte count.
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> bytes_left_r != '0)
    else $error("payload phase with no bytes left");

  // The fault count never decreases and grows by at most one per step.
  a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> (fault_r == $past(fault_r)) || (fault_r == $past(fault_r) + 1'b1))
    else $error("fault count moved by more than one");

  // A framing error always sends the parser back to idle.
  a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !byte_ok |=> phase_r == PH_IDLE)
    else $error("framing error did not return to idle");

endmodule

>>> rtl/serial_frame_parser_xor_check_unit.sv
// Top level of the serial frame parser with XOR checksum.
//
// One received byte enters per transaction on the in_ channel; every byte
// yields exactly one result transaction on the out_ channel: absorbed,
// payload byte (with a flag on the frame's final byte), frame good, checksum
// bad or framing error, along with the frame's function code and length and
// the saturating fault count.
// The cfg_ channel writes the header, tail and limit registers; it is always
// ready and is meant to be used only while no transaction is in flight.
// A byte is captured in the input register, then the frame state machine
// processes it into the result register. One byte per cycle is sustained
// while the output is not stalled.
// A stall on the output holds the result register; the input register still
// takes one more byte, after which in_ready drops until the result is taken.
// Synchronous reset empties both registers, returns the parser to idle with
// a zero fault count and restores the configuration defaults.
module serial_frame_parser_xor_check_unit
  import sfpx_pkg::*;
#(
  parameter int unsigned FAULT_COUNT_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  sfpx_in_if.sink    in_ch,
  sfpx_out_if.source out_ch,
  sfpx_cfg_if.sink   cfg_ch
);

  cfg_t              cfg_r;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           result;
  logic              out_free;
  logic              step_en;

  assign out_free = !out_valid_r || out_ch.ready;
  assign step_en  = in_valid_r && out_free;

  assign in_ch.ready  = !in_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= HEADER_FIRST_RST;
      cfg_r.header_second  <= HEADER_SECOND_RST;
      cfg_r.tail_first     <= TAIL_FIRST_RST;
      cfg_r.tail_second    <= TAIL_SECOND_RST;
      cfg_r.function_limit <= FUNCTION_LIMIT_RST;
      cfg_r.length_limit   <= LENGTH_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_HEADER_FIRST:   cfg_r.header_first   <= cfg_ch.data[BYTE_W-1:0];
        REG_HEADER_SECOND:  cfg_r.header_second  <= cfg_ch.data[BYTE_W-1:0];
        REG_TAIL_FIRST:     cfg_r.tail_first     <= cfg_ch.data[BYTE_W-1:0];
        REG_TAIL_SECOND:    cfg_r.tail_second    <= cfg_ch.data[BYTE_W-1:0];
        REG_FUNCTION_LIMIT: cfg_r.function_limit <= cfg_ch.data;
        REG_LENGTH_LIMIT:   cfg_r.length_limit   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  sfpx_fsm #(
    .FAULT_COUNT_BITS(FAULT_COUNT_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .rx_byte(in_byte_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_res      = out_r.event_res;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.last_payload   = out_r.last_payload;
  assign out_ch.function_code  = out_r.function_code;
  assign out_ch.payload_length = out_r.payload_length;
  assign out_ch.fault_total    = out_r.fault_total;

  // A held byte in the input register stays put until it is processed.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_en |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a byte");

  // The input side only blocks when both registers are full and stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_valid_r && out_valid_r && !out_ch.ready)
    else $error("input blocked without a stall");

  // The final-payload flag only travels with a payload event.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_payload |-> out_r.event_res == EV_PAYLOAD)
    else $error("last payload flag on a non-payload event");

  // Payload events always carry a non-zero frame length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_res == EV_PAYLOAD |-> out_r.payload_length != '0)
    else $error("payload event with zero frame length");

endmodule
